// ===== design/dmpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_pkg
// Shared widths, register indexes, reset values and saturating helpers for
// the movement primitive integrator.
// ----------------------------------------------------------------------------
package dmpi_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int JOINT_W = 3;
  localparam int STEP_W  = 16;
  localparam int CFG_W   = 3;

  // Register indexes on the config port
  localparam logic [CFG_W-1:0] CFG_ALPHA     = 3'd0;
  localparam logic [CFG_W-1:0] CFG_BETA      = 3'd1;
  localparam logic [CFG_W-1:0] CFG_TAU       = 3'd2;
  localparam logic [CFG_W-1:0] CFG_TAU_INV   = 3'd3;
  localparam logic [CFG_W-1:0] CFG_DT        = 3'd4;
  localparam logic [CFG_W-1:0] CFG_LENGTH    = 3'd5;
  localparam logic [CFG_W-1:0] CFG_FORCED    = 3'd6;

  // Register reset values
  localparam logic [DATA_W-1:0] ALPHA_RST   = 32'd1638400;
  localparam logic [DATA_W-1:0] BETA_RST    = 32'd409600;
  localparam logic [DATA_W-1:0] TAU_RST     = 32'd65536;
  localparam logic [DATA_W-1:0] TAU_INV_RST = 32'd65536;
  localparam logic [STEP_W-1:0] DT_RST      = 16'd655;
  localparam logic [STEP_W-1:0] LENGTH_RST  = 16'd100;
  localparam logic [STEP_W-1:0] FORCED_RST  = 16'd100;

  // Item opcodes
  localparam logic OP_INIT    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Control from sequencer to the shared multiplier
  typedef struct packed {
    logic issue;   // load product register
    logic finish;  // load rounded/saturated result
    logic q16;     // 1: round and drop 16 fraction bits, 0: integer product
  } mul_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_sub = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_sub = s[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== design/dmpi_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_state_mem
// Per-joint state memory, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module dmpi_state_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int WIDTH  = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dmpi_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_mul
// Shared signed multiplier: product stage, then round-half-up and shift (Q16 mode only), saturate.
// ----------------------------------------------------------------------------
module dmpi_mul (
  input  logic                                   clk,
  input  dmpi_pkg::mul_ctl_t                     ctl,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     op_a,
  input  logic signed [dmpi_pkg::DATA_W:0]       op_b,
  output logic signed [dmpi_pkg::DATA_W-1:0]     res
);

  import dmpi_pkg::*;

  localparam int PROD_W = 2 * DATA_W + 1;
  localparam logic signed [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic                     q16_r;
  logic signed [DATA_W-1:0] res_r;

  logic signed [PROD_W:0]   biased;
  logic signed [PROD_W:0]   shifted;
  logic signed [DATA_W-1:0] sat_val;
  logic [PROD_W-DATA_W+1:0] hi_bits;

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r <= op_a * op_b;
      q16_r  <= ctl.q16;
    end
    if (ctl.finish) begin
      res_r <= sat_val;
    end
  end

  always_comb begin
    biased  = {prod_r[PROD_W-1], prod_r} + (q16_r ? HALF_LSB : '0);
    shifted = q16_r ? (biased >>> FRAC_W) : biased;
    hi_bits = shifted[PROD_W:DATA_W-1];
    if (&hi_bits || ~|hi_bits) begin
      sat_val = shifted[DATA_W-1:0];
    end else if (shifted[PROD_W]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign res = res_r;

endmodule

// ===== design/movement_primitive_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movement_primitive_integrator
// Per-joint dynamic movement primitive integrator in signed Q16.16.
// ----------------------------------------------------------------------------
// Each joint keeps its position and velocity in a small state memory. An init
// transfer (op 0) stores the start position and velocity and returns them as
// step 0. An advance transfer (op 1) reads the joint's state, runs eleven
// dependent multiplies through one shared multiplier, each passing through
// multiply, round/saturate and combine, writes the new state back and returns
// it. A new item is taken only once the previous one has reached the output
// register. A finished result waits in the output register, so the next item
// can be taken while it is still stalled. Joint indexes fold onto JOINTS
// entries by modulo; the reply echoes the joint index as received.
// Configuration is to be written through the cfg_ port only while no item is
// in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module movement_primitive_integrator #(
  parameter int JOINTS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_op,
  input  logic [dmpi_pkg::JOINT_W-1:0]           in_joint,
  input  logic [dmpi_pkg::STEP_W-1:0]            in_step_index,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     in_start_position,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     in_start_velocity,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     in_goal_position,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     in_goal_velocity,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     in_amplitude,
  input  logic signed [dmpi_pkg::DATA_W-1:0]     in_forcing,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dmpi_pkg::JOINT_W-1:0]           out_joint,
  output logic [dmpi_pkg::STEP_W-1:0]            out_step,
  output logic signed [dmpi_pkg::DATA_W-1:0]     out_position,
  output logic signed [dmpi_pkg::DATA_W-1:0]     out_velocity,
  // configuration
  input  logic                                   cfg_we,
  input  logic [dmpi_pkg::CFG_W-1:0]             cfg_index,
  input  logic [dmpi_pkg::DATA_W-1:0]            cfg_wdata
);

  import dmpi_pkg::*;

  localparam int AW      = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int STATE_W = 2 * DATA_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_ISSUE = 6'b000100,
    S_ROUND = 6'b001000,
    S_POST  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Multiply chain, in issue order
  typedef enum logic [3:0] {
    M_GV, M_DTERM, M_GVD, M_SHIFT, M_PTERM, M_A1,
    M_FTERM, M_ACC1, M_ACC, M_DV, M_DP
  } mul_step_t;

  state_t    state_r, state_nxt;
  mul_step_t mstep_r, mstep_nxt;

  // configuration registers
  logic [DATA_W-1:0] alpha_r, beta_r, tau_r, tau_inv_r;
  logic [STEP_W-1:0] dt_r, len_r, forced_r;

  // captured item
  logic [JOINT_W-1:0]       joint_r;
  logic [AW-1:0]            slot_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [DATA_W-1:0] goal_r, gvel_r, amp_r, frc_r;

  // working registers
  logic signed [DATA_W-1:0] gv_r, tmp_r, y_r, yd_r;
  logic signed [DATA_W-1:0] gv_nxt, tmp_nxt, y_nxt, yd_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic signed [DATA_W:0]   b_r, b_nxt;
  logic                     q16_r, q16_nxt;

  // output register
  logic                     out_valid_r;
  logic [JOINT_W-1:0]       out_joint_r;
  logic [STEP_W-1:0]        out_step_r;
  logic signed [DATA_W-1:0] out_pos_r, out_vel_r;

  logic                     in_xfer;
  logic                     out_free;
  logic                     wb_en;
  logic [AW-1:0]            in_slot;
  logic [STATE_W-1:0]       rd_data;
  logic signed [DATA_W-1:0] y0, yd0;
  logic signed [DATA_W-1:0] mul_res;
  logic signed [STEP_W:0]   rem;
  logic signed [DATA_W:0]   rem_ext;
  logic signed [DATA_W:0]   fs_ext;
  logic signed [DATA_W:0]   tau_ext, tau_inv_ext, alpha_ext, beta_ext, dt_ext;
  mul_ctl_t                 mul_ctl;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign wb_en    = (state_r == S_DONE) && out_free;

  // joint index modulo JOINTS as a small constant table
  always_comb begin
    in_slot = '0;
    for (int i = 0; i < 2 ** JOINT_W; i++) begin
      if (in_joint == JOINT_W'(i)) begin
        in_slot = AW'(i % JOINTS);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= ALPHA_RST;
      beta_r    <= BETA_RST;
      tau_r     <= TAU_RST;
      tau_inv_r <= TAU_INV_RST;
      dt_r      <= DT_RST;
      len_r     <= LENGTH_RST;
      forced_r  <= FORCED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:   alpha_r   <= cfg_wdata;
        CFG_BETA:    beta_r    <= cfg_wdata;
        CFG_TAU:     tau_r     <= cfg_wdata;
        CFG_TAU_INV: tau_inv_r <= cfg_wdata;
        CFG_DT:      dt_r      <= cfg_wdata[STEP_W-1:0];
        CFG_LENGTH:  len_r     <= cfg_wdata[STEP_W-1:0];
        CFG_FORCED:  forced_r  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State memory: {position, velocity} per joint
  // --------------------------------------------------------------------------
  dmpi_state_mem #(
    .DEPTH  (JOINTS),
    .ADDR_W (AW),
    .WIDTH  (STATE_W)
  ) u_state_mem (
    .clk     (clk),
    .wr_en   (wb_en),
    .wr_addr (slot_r),
    .wr_data ({y_r, yd_r}),
    .rd_en   (state_r == S_READ),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // read data is held from the cycle after S_READ through the whole chain
  assign y0  = rd_data[STATE_W-1:DATA_W];
  assign yd0 = rd_data[DATA_W-1:0];

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  assign mul_ctl.issue  = (state_r == S_ISSUE);
  assign mul_ctl.finish = (state_r == S_ROUND);
  assign mul_ctl.q16    = q16_r;

  dmpi_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .op_a (a_r),
    .op_b (b_r),
    .res  (mul_res)
  );

  // operand forms of the config values and item fields
  assign tau_ext     = {1'b0, tau_r};
  assign tau_inv_ext = {1'b0, tau_inv_r};
  assign alpha_ext   = {1'b0, alpha_r};
  assign beta_ext    = {1'b0, beta_r};
  assign dt_ext      = {{(DATA_W-STEP_W+1){1'b0}}, dt_r};
  // remaining steps, signed: zero or negative past the end
  assign rem         = {1'b0, len_r} - {1'b0, step_r};
  assign rem_ext     = {{(DATA_W-STEP_W){rem[STEP_W]}}, rem};
  // forcing drops to zero from forced_steps on
  assign fs_ext      = (step_r < forced_r) ? {frc_r[DATA_W-1], frc_r} : '0;

  // --------------------------------------------------------------------------
  // Combine stage: fold the last product in, set up the next multiply
  // --------------------------------------------------------------------------
  always_comb begin
    gv_nxt    = gv_r;
    tmp_nxt   = tmp_r;
    y_nxt     = y_r;
    yd_nxt    = yd_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    q16_nxt   = 1'b1;
    mstep_nxt = mstep_r;
    case (mstep_r)
      M_GV: begin
        gv_nxt    = mul_res;
        a_nxt     = sat_sub(mul_res, yd0);
        b_nxt     = tau_inv_ext;
        mstep_nxt = M_DTERM;
      end
      M_DTERM: begin
        tmp_nxt   = mul_res;
        a_nxt     = gv_r;
        b_nxt     = dt_ext;
        mstep_nxt = M_GVD;
      end
      M_GVD: begin
        // goal shift uses an integer step count, no fraction drop
        a_nxt     = mul_res;
        b_nxt     = rem_ext;
        q16_nxt   = 1'b0;
        mstep_nxt = M_SHIFT;
      end
      M_SHIFT: begin
        a_nxt     = sat_sub(sat_sub(goal_r, mul_res), y0);
        b_nxt     = beta_ext;
        mstep_nxt = M_PTERM;
      end
      M_PTERM: begin
        a_nxt     = sat_add(mul_res, tmp_r);
        b_nxt     = alpha_ext;
        mstep_nxt = M_A1;
      end
      M_A1: begin
        tmp_nxt   = mul_res;
        a_nxt     = amp_r;
        b_nxt     = fs_ext;
        mstep_nxt = M_FTERM;
      end
      M_FTERM: begin
        a_nxt     = sat_add(tmp_r, mul_res);
        b_nxt     = tau_ext;
        mstep_nxt = M_ACC1;
      end
      M_ACC1: begin
        a_nxt     = mul_res;
        b_nxt     = tau_ext;
        mstep_nxt = M_ACC;
      end
      M_ACC: begin
        a_nxt     = mul_res;
        b_nxt     = dt_ext;
        mstep_nxt = M_DV;
      end
      M_DV: begin
        // symplectic Euler: velocity first, position from the new velocity
        yd_nxt    = sat_add(yd0, mul_res);
        a_nxt     = yd_nxt;
        b_nxt     = dt_ext;
        mstep_nxt = M_DP;
      end
      M_DP: begin
        y_nxt     = sat_add(y0, mul_res);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = (in_op == OP_INIT) ? S_DONE : S_READ;
      S_READ:  state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_POST;
      S_POST:  state_nxt = (mstep_r == M_DP) ? S_DONE : S_ISSUE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      joint_r <= in_joint;
      slot_r  <= in_slot;
      step_r  <= (in_op == OP_INIT) ? '0 : in_step_index;
      goal_r  <= in_goal_position;
      gvel_r  <= in_goal_velocity;
      amp_r   <= in_amplitude;
      frc_r   <= in_forcing;
      y_r     <= in_start_position;
      yd_r    <= in_start_velocity;
    end
    if (state_r == S_READ) begin
      a_r     <= gvel_r;
      b_r     <= tau_ext;
      q16_r   <= 1'b1;
      mstep_r <= M_GV;
    end
    if (state_r == S_POST) begin
      gv_r    <= gv_nxt;
      tmp_r   <= tmp_nxt;
      y_r     <= y_nxt;
      yd_r    <= yd_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      q16_r   <= q16_nxt;
      mstep_r <= mstep_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      out_joint_r <= joint_r;
      out_step_r  <= step_r;
      out_pos_r   <= y_r;
      out_vel_r   <= yd_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_joint    = out_joint_r;
  assign out_step     = out_step_r;
  assign out_position = out_pos_r;
  assign out_velocity = out_vel_r;

endmodule

// ===== bench/movement_primitive_integrator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movement_primitive_integrator_tb
// Self-checking bench for the per-joint movement primitive integrator. A
// bit-exact Q16.16 predictor tracks every joint's position and velocity and
// the register file. Each accepted transfer pushes the predicted point, and a
// monitor compares each returned point field by field in order. Stimulus runs
// directed extremes, register extremes, and random trajectory phases under
// random idling on both channels, then a back-to-back tail.
// ----------------------------------------------------------------------------
module movement_primitive_integrator_tb;
  import dmpi_pkg::*;

  localparam int JOINTS = 8;
  localparam int STEP_CAP = 40;  // longest trajectory run per burst
  localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] NEG_MAX = 32'sh8000_0000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // one input transfer
  typedef struct packed {
    logic                     op;
    logic [JOINT_W-1:0]       joint;
    logic [STEP_W-1:0]        step;
    logic signed [DATA_W-1:0] start_position;
    logic signed [DATA_W-1:0] start_velocity;
    logic signed [DATA_W-1:0] goal_position;
    logic signed [DATA_W-1:0] goal_velocity;
    logic signed [DATA_W-1:0] amplitude;
    logic signed [DATA_W-1:0] forcing;
  } move_item_t;

  // one returned trajectory point
  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic [STEP_W-1:0]        step;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
  } point_t;

  // register file image, indexed by the CFG_* codes
  typedef logic [CFG_FORCED:0][DATA_W-1:0] reg_file_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_op = OP_INIT;
  logic [JOINT_W-1:0]       in_joint = '0;
  logic [STEP_W-1:0]        in_step_index = '0;
  logic signed [DATA_W-1:0] in_start_position = '0;
  logic signed [DATA_W-1:0] in_start_velocity = '0;
  logic signed [DATA_W-1:0] in_goal_position = '0;
  logic signed [DATA_W-1:0] in_goal_velocity = '0;
  logic signed [DATA_W-1:0] in_amplitude = '0;
  logic signed [DATA_W-1:0] in_forcing = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [JOINT_W-1:0]       out_joint;
  logic [STEP_W-1:0]        out_step;
  logic signed [DATA_W-1:0] out_position;
  logic signed [DATA_W-1:0] out_velocity;

  logic                     cfg_we = 1'b0;
  logic [CFG_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;

  // predictor state: registers and per-joint position / velocity
  reg_file_t                shadow_regs = {DATA_W'(FORCED_RST), DATA_W'(LENGTH_RST),
                                           DATA_W'(DT_RST), TAU_INV_RST, TAU_RST,
                                           BETA_RST, ALPHA_RST};
  logic signed [DATA_W-1:0] track_pos [JOINTS];
  logic signed [DATA_W-1:0] track_vel [JOINTS];
  logic [JOINTS-1:0]        joint_ready = '0;  // joints that have seen an init

  point_t pending_points [$];
  int     mismatches = 0;
  int     sent_items = 0;
  bit     idle_on = 1'b1;
  int     stall_left = 0;

  movement_primitive_integrator #(
    .JOINTS(JOINTS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_joint         (in_joint),
    .in_step_index    (in_step_index),
    .in_start_position(in_start_position),
    .in_start_velocity(in_start_velocity),
    .in_goal_position (in_goal_position),
    .in_goal_velocity (in_goal_velocity),
    .in_amplitude     (in_amplitude),
    .in_forcing       (in_forcing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_joint        (out_joint),
    .out_step         (out_step),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Generous backstop against a hung run.
  initial begin
    #8_000_000;
    $display("movement_primitive_integrator: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > S32_MAX) return POS_MAX;
    if (v < S32_MIN) return NEG_MAX;
    return v[DATA_W-1:0];
  endfunction

  // exact product; for Q16.16 operands round half up and drop 16 bits
  function automatic logic signed [DATA_W-1:0] rounded_product(
    input logic signed [DATA_W-1:0] a,
    input longint                   b,
    input bit                       q16
  );
    longint p;
    p = longint'(a) * b;
    if (q16) p = (p + 64'sd32768) >>> FRAC_W;
    return clamp32(p);
  endfunction

  function automatic logic signed [DATA_W-1:0] sum_sat(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] diff_sat(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return clamp32(longint'(a) - longint'(b));
  endfunction

  // Work out the point one transfer returns and update the joint's state.
  function automatic point_t integrate_step(input move_item_t it);
    point_t                   pt;
    logic signed [DATA_W-1:0] y0, yd0, gv, gshift, gt, pterm, dterm;
    logic signed [DATA_W-1:0] a1, fs, fterm, acc;
    longint                   tau, dt, rem;
    int                       slot;
    slot = it.joint % JOINTS;
    pt.joint = it.joint;
    if (it.op == OP_INIT) begin
      pt.step = '0;
      pt.position = it.start_position;
      pt.velocity = it.start_velocity;
    end else begin
      y0  = track_pos[slot];
      yd0 = track_vel[slot];
      tau = longint'(shadow_regs[CFG_TAU]);
      dt  = longint'(shadow_regs[CFG_DT][STEP_W-1:0]);
      // remaining steps go negative past the end of the trajectory
      rem = longint'(shadow_regs[CFG_LENGTH][STEP_W-1:0]) - longint'(it.step);
      gv     = rounded_product(it.goal_velocity, tau, 1'b1);
      gshift = rounded_product(rounded_product(gv, dt, 1'b1), rem, 1'b0);
      gt     = diff_sat(it.goal_position, gshift);
      pterm  = rounded_product(diff_sat(gt, y0), longint'(shadow_regs[CFG_BETA]), 1'b1);
      dterm  = rounded_product(diff_sat(gv, yd0), longint'(shadow_regs[CFG_TAU_INV]),
                               1'b1);
      a1     = rounded_product(sum_sat(pterm, dterm), longint'(shadow_regs[CFG_ALPHA]),
                               1'b1);
      // forcing drops out from forced_steps onward
      fs     = (it.step < shadow_regs[CFG_FORCED][STEP_W-1:0]) ? it.forcing : '0;
      fterm  = rounded_product(it.amplitude, longint'(fs), 1'b1);
      acc    = rounded_product(rounded_product(sum_sat(a1, fterm), tau, 1'b1), tau, 1'b1);
      // symplectic Euler: velocity first, position from the new velocity
      pt.velocity = sum_sat(yd0, rounded_product(acc, dt, 1'b1));
      pt.position = sum_sat(y0, rounded_product(pt.velocity, dt, 1'b1));
      pt.step = it.step;
    end
    track_pos[slot] = pt.position;
    track_vel[slot] = pt.velocity;
    return pt;
  endfunction

  // --------------------------------------------------------------------------
  // Random value helpers
  // --------------------------------------------------------------------------
  // full range with the corners weighted in
  function automatic logic signed [DATA_W-1:0] any_word();
    case ($urandom_range(0, 7))
      0:       return NEG_MAX;
      1:       return POS_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // roughly +/-16.0, keeps trajectories out of saturation
  function automatic logic signed [DATA_W-1:0] near_word();
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic reg_file_t random_regs(input bit wide);
    reg_file_t r;
    if (wide) begin
      r[CFG_ALPHA]   = $urandom;
      r[CFG_BETA]    = $urandom;
      r[CFG_TAU]     = $urandom | 32'd1;
      r[CFG_TAU_INV] = $urandom | 32'd1;
      r[CFG_DT]      = $urandom_range(0, 16'hffff);
      r[CFG_LENGTH]  = $urandom_range(1, 16'hffff);
      r[CFG_FORCED]  = $urandom_range(0, 16'hffff);
    end else begin
      r[CFG_ALPHA]   = $urandom_range(0, 50 << FRAC_W);
      r[CFG_BETA]    = $urandom_range(0, 20 << FRAC_W);
      r[CFG_TAU]     = $urandom_range(16384, 262144);
      // usually a matching reciprocal, sometimes an unrelated one
      if ($urandom_range(0, 3) != 0) r[CFG_TAU_INV] = DATA_W'(64'h1_0000_0000 / r[CFG_TAU]);
      else r[CFG_TAU_INV] = $urandom_range(1, 4 << FRAC_W);
      r[CFG_DT]      = $urandom_range(0, 6554);
      r[CFG_LENGTH]  = $urandom_range(2, STEP_CAP);
      r[CFG_FORCED]  = $urandom_range(0, r[CFG_LENGTH] + 3);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------
  // Present one transfer, hold it until accepted, then record the prediction.
  // in_valid is left high so a following item can go out back to back.
  task automatic send_item(input move_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_op             <= it.op;
    in_joint          <= it.joint;
    in_step_index     <= it.step;
    in_start_position <= it.start_position;
    in_start_velocity <= it.start_velocity;
    in_goal_position  <= it.goal_position;
    in_goal_velocity  <= it.goal_velocity;
    in_amplitude      <= it.amplitude;
    in_forcing        <= it.forcing;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(integrate_step(it));
    if (it.op == OP_INIT) joint_ready[it.joint % JOINTS] = 1'b1;
    sent_items++;
  endtask

  task automatic init_joint(input logic [JOINT_W-1:0] joint,
                            input logic signed [DATA_W-1:0] pos,
                            input logic signed [DATA_W-1:0] vel);
    move_item_t it;
    it = {OP_INIT, joint, STEP_W'($urandom), pos, vel,
          any_word(), any_word(), any_word(), any_word()};
    send_item(it);
  endtask

  task automatic advance(input logic [JOINT_W-1:0] joint,
                         input logic [STEP_W-1:0] step,
                         input logic signed [DATA_W-1:0] goal,
                         input logic signed [DATA_W-1:0] gvel,
                         input logic signed [DATA_W-1:0] amp,
                         input logic signed [DATA_W-1:0] frc);
    move_item_t it;
    it = {OP_ADVANCE, joint, step, any_word(), any_word(), goal, gvel, amp, frc};
    send_item(it);
  endtask

  // Drop valid and wait until every predicted point has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the whole register file in consecutive cycles; block must be idle.
  task automatic program_regs(input reg_file_t r);
    cfg_we <= 1'b1;
    for (int i = CFG_ALPHA; i <= CFG_FORCED; i++) begin
      cfg_index <= CFG_W'(i);
      cfg_wdata <= r[CFG_W'(i)];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    shadow_regs = r;
  endtask

  // Init a joint, then walk it through its steps with a fixed goal.
  task automatic run_trajectory(input logic [JOINT_W-1:0] joint);
    logic signed [DATA_W-1:0] goal, gvel, amp;
    int                       last;
    goal = near_word();
    gvel = near_word() >>> 4;
    amp  = near_word();
    last = shadow_regs[CFG_LENGTH][STEP_W-1:0] - 1;
    if (last > STEP_CAP) last = STEP_CAP;
    init_joint(joint, near_word(), near_word() >>> 2);
    for (int s = 1; s <= last; s++) advance(joint, STEP_W'(s), goal, gvel, amp, near_word());
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts and the in-order checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 14);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%t ERROR: %s expected 0x%h actual 0x%h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%t ERROR: unexpected point, expected none, actual joint %0d step %0d",
                 $time, out_joint, out_step);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        report_field("joint", DATA_W'(want.joint), DATA_W'(out_joint));
        report_field("step", DATA_W'(want.step), DATA_W'(out_step));
        report_field("position", want.position, out_position);
        report_field("velocity", want.velocity, out_velocity);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values; corner inputs, step at and past the trajectory end,
  // forcing cut-off boundary, re-init of a live joint.
  task automatic test_directed_extremes();
    init_joint(3'd0, POS_MAX, NEG_MAX);
    init_joint(3'd1, NEG_MAX, POS_MAX);
    for (int j = 2; j < JOINTS; j++) init_joint(JOINT_W'(j), near_word(), near_word());
    advance(3'd2, 16'd1, near_word(), near_word(), near_word(), near_word());
    advance(3'd2, 16'd99, near_word(), near_word(), near_word(), near_word());
    // step equal to length: nothing left to shift, forcing just switched off
    advance(3'd2, 16'd100, near_word(), near_word(), near_word(), near_word());
    advance(3'd2, 16'hffff, near_word(), near_word(), near_word(), near_word());
    advance(3'd3, 16'd0, near_word(), near_word(), near_word(), near_word());
    advance(3'd0, 16'd50, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    advance(3'd1, 16'd1, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
    advance(3'd4, 16'd7, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX);
    advance(3'd5, 16'd99, '0, '0, NEG_MAX, POS_MAX);
    advance(3'd6, 16'h8000, near_word(), near_word(), '1, '1);
    init_joint(3'd2, '0, '0);
    advance(3'd2, 16'd2, '0, '0, '0, '0);
    advance(3'd7, 16'd98, near_word(), near_word(), near_word(), near_word());
    settle();
  endtask

  // Register corners: everything at its low end, everything at its high end,
  // then the longest step with moderate gains.
  task automatic test_register_extremes();
    reg_file_t r;
    r[CFG_ALPHA] = '0;  r[CFG_BETA] = '0;  r[CFG_TAU] = 32'd1;  r[CFG_TAU_INV] = 32'd1;
    r[CFG_DT] = '0;  r[CFG_LENGTH] = 32'd1;  r[CFG_FORCED] = '0;
    program_regs(r);
    init_joint(3'd0, near_word(), near_word());
    advance(3'd0, 16'd0, near_word(), near_word(), POS_MAX, POS_MAX);
    advance(3'd0, 16'd1, POS_MAX, NEG_MAX, near_word(), near_word());
    advance(3'd1, 16'hffff, NEG_MAX, POS_MAX, NEG_MAX, NEG_MAX);
    settle();
    r[CFG_ALPHA] = '1;  r[CFG_BETA] = '1;  r[CFG_TAU] = '1;  r[CFG_TAU_INV] = '1;
    r[CFG_DT] = 32'hffff;  r[CFG_LENGTH] = 32'hffff;  r[CFG_FORCED] = 32'hffff;
    program_regs(r);
    advance(3'd0, 16'd0, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    advance(3'd3, 16'hfffe, NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX);
    advance(3'd4, 16'hffff, near_word(), near_word(), near_word(), near_word());
    init_joint(3'd5, near_word(), near_word());
    advance(3'd5, 16'd1, near_word(), near_word(), near_word(), near_word());
    settle();
    r = random_regs(1'b0);
    r[CFG_DT] = 32'hffff;
    program_regs(r);
    run_trajectory(3'd6);
    settle();
  endtask

  // Random register phases; mostly well-formed trajectories with random
  // content, mixed with stray inits and out-of-sequence advances.
  task automatic test_random_trajectories();
    int               phase_end;
    logic [JOINT_W-1:0] j;
    for (int phase = 0; phase < 7; phase++) begin
      program_regs(random_regs(phase == 3 || phase == 6));
      phase_end = sent_items + 200;
      while (sent_items < phase_end) begin
        // some stretches run with no idling at all
        idle_on = ($urandom_range(0, 4) != 0);
        j = JOINT_W'($urandom);
        case ($urandom_range(0, 9))
          8: if (joint_ready[j % JOINTS])
               advance(j, STEP_W'($urandom), any_word(), any_word(), any_word(), any_word());
             else
               init_joint(j, any_word(), any_word());
          9: init_joint(j, any_word(), any_word());
          default: run_trajectory(j);
        endcase
      end
      idle_on = 1'b1;
      settle();
    end
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_quiet_tail();
    int tail_end;
    idle_on = 1'b0;
    program_regs(random_regs(1'b0));
    tail_end = sent_items + 100;
    while (sent_items < tail_end) run_trajectory(JOINT_W'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_register_extremes();
    test_random_trajectories();
    test_quiet_tail();
    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("movement_primitive_integrator: match");
    end else begin
      $display("movement_primitive_integrator: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dmpi_pkg.sv
design/dmpi_state_mem.sv
design/dmpi_mul.sv
design/movement_primitive_integrator.sv
bench/movement_primitive_integrator_tb.sv
